FILE: hw/rtl/afsp_pkg.sv
// shared types and constants for the accelerometer fifo frame parser
`default_nettype none
package afsp_pkg;

  localparam int unsigned PAYLOAD_BYTES = 6;
  localparam int unsigned PHASE_W       = 3;
  localparam logic [7:0]  SYNC_HEADER   = 8'h84;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_Z = 2'd2;

  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 64;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } offsets_t;

  typedef struct packed {
    logic               frame_valid;
    logic signed [16:0] accel_x;
    logic signed [16:0] accel_y;
    logic signed [16:0] accel_z;
    logic               batch_done;
    logic [7:0]         frames_parsed;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/accel_fifo_frame_sync_parser_core.sv
// Accelerometer FIFO frame parser: top level with config registers and output skid
//
// Input stream s_*: one FIFO byte per beat, s_tdata = {frame_limit, fifo_byte},
// s_tlast marks the last byte of a batch. Bytes other than the 0x84 header are
// skipped while hunting; a header is followed by six payload bytes, three
// little-endian signed 16-bit axes x, y, z. Each axis has its offset subtracted.
// Output stream m_*: a beat is sent when a frame completes, on the batch's last
// byte, or both. m_tuser = frame_valid, m_tlast = batch_done,
// m_tdata = {zeros, frames_parsed, accel_z, accel_y, accel_x}.
// Config channel cfg_*: index 0/1/2 writes offset x/y/z; cfg_ready is always high.
// A result is registered onto m_* from the byte that causes it, via the skid register if m_* is stalled.
// Throughput: one byte per cycle while s_tready is high, through the parser and output register.
// When m_tready is low, one further result goes into a skid register and s_tready
// drops until the skid register drains.
// Reset clears the parser phase, the frame count, the offsets and both output valid flags.
`default_nettype none
module accel_fifo_frame_sync_parser_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [afsp_pkg::S_TDATA_W-1:0]      s_tdata,  // fifo_byte[7:0], frame_limit[15:8]
  input  wire logic                                s_tlast,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [afsp_pkg::M_TDATA_W-1:0]           m_tdata,  // accel_x, accel_y, accel_z, frames_parsed
  output logic                                     m_tuser,  // frame_valid
  output logic                                     m_tlast,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [afsp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [15:0]                         cfg_data
);
  import afsp_pkg::*;

  offsets_t offsets;
  logic     beat;
  logic     res_valid;
  result_t  res;
  result_t  out_res;
  logic     skid_valid;
  result_t  skid_res;
  logic     out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = ~skid_valid;
  assign beat      = s_tvalid & s_tready;
  assign out_free  = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      offsets <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OFFSET_X: offsets.x <= cfg_data;
        CFG_OFFSET_Y: offsets.y <= cfg_data;
        CFG_OFFSET_Z: offsets.z <= cfg_data;
        default: ;
      endcase
    end
  end

  afsp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .beat        (beat),
    .fifo_byte   (s_tdata[7:0]),
    .batch_end   (s_tlast),
    .frame_limit (s_tdata[15:8]),
    .offsets     (offsets),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= beat & res_valid;
      end
    end else if (beat & res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (beat & res_valid) begin
      skid_res <= res;
    end
  end

  assign m_tdata = {5'b0, out_res.frames_parsed, out_res.accel_z, out_res.accel_y,
                    out_res.accel_x};
  assign m_tuser = out_res.frame_valid;
  assign m_tlast = out_res.batch_done;

endmodule
`default_nettype wire

FILE: hw/rtl/afsp_parser.sv
// header hunt, payload assembly, offset subtraction and per-batch frame count
`default_nettype none
module afsp_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              beat,
  input  wire logic [7:0]        fifo_byte,
  input  wire logic              batch_end,
  input  wire logic [7:0]        frame_limit,
  input  wire afsp_pkg::offsets_t offsets,
  output logic                   res_valid,
  output afsp_pkg::result_t      res
);
  import afsp_pkg::*;

  logic [PHASE_W-1:0] payload_phase;
  logic [PHASE_W-1:0] payload_phase_next;
  logic [39:0]        payload_bytes;
  logic [39:0]        payload_bytes_next;
  logic [7:0]         frame_count;
  logic [7:0]         frame_count_next;
  logic               frame;
  logic [15:0]        raw_x;
  logic [15:0]        raw_y;
  logic [15:0]        raw_z;
  logic [7:0]         count_inc;

  assign raw_x     = payload_bytes[15:0];
  assign raw_y     = payload_bytes[31:16];
  assign raw_z     = {fifo_byte, payload_bytes[39:32]};
  assign count_inc = (frame_count == 8'hFF) ? frame_count : frame_count + 8'd1;

  always_comb begin
    payload_phase_next = payload_phase;
    payload_bytes_next = payload_bytes;
    frame_count_next   = frame_count;
    frame              = 1'b0;
    if (payload_phase == '0 || payload_phase > PHASE_W'(PAYLOAD_BYTES)) begin
      payload_phase_next = '0;
      if (fifo_byte == SYNC_HEADER && frame_count < frame_limit) begin
        payload_phase_next = PHASE_W'(1);
      end
    end else if (payload_phase < PHASE_W'(PAYLOAD_BYTES)) begin
      unique case (payload_phase)
        3'd1:    payload_bytes_next[7:0]   = fifo_byte;
        3'd2:    payload_bytes_next[15:8]  = fifo_byte;
        3'd3:    payload_bytes_next[23:16] = fifo_byte;
        3'd4:    payload_bytes_next[31:24] = fifo_byte;
        default: payload_bytes_next[39:32] = fifo_byte;
      endcase
      payload_phase_next = payload_phase + PHASE_W'(1);
    end else begin
      frame              = 1'b1;
      frame_count_next   = count_inc;
      payload_phase_next = '0;
    end
    if (batch_end) begin
      payload_phase_next = '0;
      frame_count_next   = '0;
    end
  end

  always_comb begin
    res_valid         = frame | batch_end;
    res.frame_valid   = frame;
    res.batch_done    = batch_end;
    res.frames_parsed = frame ? count_inc : frame_count;
    res.accel_x       = '0;
    res.accel_y       = '0;
    res.accel_z       = '0;
    if (frame) begin
      res.accel_x = {raw_x[15], raw_x} - {offsets.x[15], offsets.x};
      res.accel_y = {raw_y[15], raw_y} - {offsets.y[15], offsets.y};
      res.accel_z = {raw_z[15], raw_z} - {offsets.z[15], offsets.z};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_phase <= '0;
      frame_count   <= '0;
    end else if (beat) begin
      payload_phase <= payload_phase_next;
      frame_count   <= frame_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      payload_bytes <= payload_bytes_next;
    end
  end

endmodule
`default_nettype wire

FILE: test/tb.sv
// self-checking testbench for the accelerometer fifo frame parser
module tb;
  import afsp_pkg::*;

  localparam int unsigned WATCHDOG_CYCLES = 400000;

  class accel_frame_checker;
    logic signed [15:0] off_x, off_y, off_z;
    logic [2:0]         phase;
    logic [39:0]        held;
    logic [7:0]         frame_count;
    result_t            pending_frames[$];
    int unsigned        errors;

    function new();
      off_x = '0;
      off_y = '0;
      off_z = '0;
      phase = '0;
      held = '0;
      frame_count = '0;
      errors = 0;
    endfunction

    function void set_offset(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
      case (idx)
        CFG_OFFSET_X: off_x = val;
        CFG_OFFSET_Y: off_y = val;
        CFG_OFFSET_Z: off_z = val;
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return pending_frames.size();
    endfunction

    // parser step for one accepted byte
    function void take_byte(logic [7:0] b, logic last, logic [7:0] lim);
      result_t r;
      logic    frame;
      int      idx;
      frame = 1'b0;
      r = '0;
      if (phase == 0 || phase > PAYLOAD_BYTES) begin
        phase = '0;
        if (b == SYNC_HEADER && frame_count < lim) begin
          phase = 3'd1;
          held = '0;
        end
      end else if (phase < PAYLOAD_BYTES) begin
        idx = int'(phase) - 1;
        held[8*idx +: 8] = b;
        phase = phase + 3'd1;
      end else begin
        r.accel_x = $signed({held[15], held[15:0]}) - $signed({off_x[15], off_x});
        r.accel_y = $signed({held[31], held[31:16]}) - $signed({off_y[15], off_y});
        r.accel_z = $signed({b[7], b, held[39:32]}) - $signed({off_z[15], off_z});
        frame = 1'b1;
        if (frame_count != 8'hFF) frame_count = frame_count + 8'd1;
        phase = '0;
        held = '0;
      end
      if (frame || last) begin
        r.frame_valid = frame;
        r.batch_done = last;
        r.frames_parsed = frame_count;
        pending_frames.push_back(r);
      end
      if (last) begin
        phase = '0;
        held = '0;
        frame_count = '0;
      end
    endfunction

    task report(string msg);
      if (errors < 100) $display("beat mismatch: %s", msg);
      errors++;
    endtask

    task check_beat(logic [M_TDATA_W-1:0] data, logic user, logic last);
      result_t got;
      result_t want;
      got.frame_valid = user;
      got.accel_x = data[16:0];
      got.accel_y = data[33:17];
      got.accel_z = data[50:34];
      got.batch_done = last;
      got.frames_parsed = data[58:51];
      if (pending_frames.size() == 0) begin
        report($sformatf("unexpected beat tdata=%h tuser=%b tlast=%b", data, user, last));
        return;
      end
      want = pending_frames.pop_front();
      if (got.frame_valid !== want.frame_valid)
        report($sformatf("frame_valid %b, want %b", got.frame_valid, want.frame_valid));
      if (got.accel_x !== want.accel_x)
        report($sformatf("accel_x %0d, want %0d", got.accel_x, want.accel_x));
      if (got.accel_y !== want.accel_y)
        report($sformatf("accel_y %0d, want %0d", got.accel_y, want.accel_y));
      if (got.accel_z !== want.accel_z)
        report($sformatf("accel_z %0d, want %0d", got.accel_z, want.accel_z));
      if (got.batch_done !== want.batch_done)
        report($sformatf("batch_done %b, want %b", got.batch_done, want.batch_done));
      if (got.frames_parsed !== want.frames_parsed)
        report($sformatf("frames_parsed %0d, want %0d", got.frames_parsed, want.frames_parsed));
    endtask
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;    // fifo_byte[7:0], frame_limit[15:8]
  logic                   s_tlast = 1'b0;  // batch_end
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;         // accel_x, accel_y, accel_z, frames_parsed
  logic                   m_tuser;         // frame_valid
  logic                   m_tlast;         // batch_done
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]            cfg_data = '0;

  int unsigned tx_idle = 0;
  int unsigned rx_idle = 0;

  accel_frame_checker frames = new();

  accel_fifo_frame_sync_parser_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) frames.check_beat(m_tdata, m_tuser, m_tlast);
  end

  initial begin : watchdog
    int unsigned n;
    for (n = 0; n < WATCHDOG_CYCLES; n++) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input logic [7:0] lim);
    while ($urandom_range(0, 99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {lim, b};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    frames.take_byte(b, last, lim);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (frames.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_offset(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    frames.set_offset(idx, val);
  endtask

  task automatic program_offsets(input logic [15:0] x, input logic [15:0] y,
                                 input logic [15:0] z);
    wait_drained();
    write_offset(CFG_OFFSET_X, x);
    write_offset(CFG_OFFSET_Y, y);
    write_offset(CFG_OFFSET_Z, z);
  endtask

  function automatic logic [7:0] rand_payload();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: return 8'h00;
        1: return 8'h7F;
        2: return 8'h80;
        default: return 8'hFF;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_frame(input logic [47:0] payload, input logic [7:0] lim,
                            input logic last);
    send_byte(SYNC_HEADER, 1'b0, lim);
    for (int i = 0; i < PAYLOAD_BYTES; i++)
      send_byte(payload[8*i +: 8], last && i == PAYLOAD_BYTES - 1, lim);
  endtask

  task automatic directed();
    // batch end while hunting, no frame
    send_byte(8'h00, 1'b1, 8'd0);
    // x = -32768, y = 32767, payload byte equal to the header
    send_frame({8'h00, 8'h84, 8'h7F, 8'hFF, 8'h80, 8'h00}, 8'd1, 1'b0);
    // limit reached: header ignored
    send_byte(SYNC_HEADER, 1'b0, 8'd1);
    send_byte(8'hFF, 1'b1, 8'd1);
    // zero limit accepts nothing
    send_byte(SYNC_HEADER, 1'b0, 8'd0);
    send_byte(SYNC_HEADER, 1'b1, 8'd0);
    // frame completes on the batch's last byte
    send_frame({8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF}, 8'd255, 1'b1);
    // cut-off payload
    send_byte(SYNC_HEADER, 1'b0, 8'd2);
    send_byte(8'h11, 1'b0, 8'd2);
    send_byte(8'h22, 1'b1, 8'd2);
  endtask

  task automatic run_traffic(input int unsigned n_bytes);
    logic [7:0]  bytes_q[$];
    logic [7:0]  lims_q[$];
    logic [7:0]  lim;
    int unsigned sent;
    int unsigned units;
    int unsigned cut;
    sent = 0;
    while (sent < n_bytes) begin
      bytes_q.delete();
      lims_q.delete();
      case ($urandom_range(0, 9))
        0: lim = 8'd0;
        1, 2: lim = 8'($urandom_range(0, 255));
        default: lim = 8'($urandom_range(1, 6));
      endcase
      units = $urandom_range(1, 7);
      for (int u = 0; u < units; u++) begin
        if ($urandom_range(0, 19) == 0) lim = 8'($urandom_range(0, 7));
        if ($urandom_range(0, 9) < 7) begin
          bytes_q.push_back(SYNC_HEADER);
          lims_q.push_back(lim);
          for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            bytes_q.push_back(rand_payload());
            lims_q.push_back(lim);
          end
        end else begin
          repeat ($urandom_range(1, 3)) begin
            bytes_q.push_back(8'($urandom_range(0, 255)));
            lims_q.push_back(lim);
          end
        end
      end
      // broken tail: header and part of a payload at batch end
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(0, PAYLOAD_BYTES - 1);
        bytes_q.push_back(SYNC_HEADER);
        lims_q.push_back(lim);
        repeat (cut) begin
          bytes_q.push_back(rand_payload());
          lims_q.push_back(lim);
        end
      end
      for (int i = 0; i < bytes_q.size(); i++)
        send_byte(bytes_q[i], i == bytes_q.size() - 1, lims_q[i]);
      sent += bytes_q.size();
    end
  endtask

  // one batch that sends more frames than its limit, so the frame count reaches the limit
  task automatic long_batch();
    logic [47:0] payload;
    for (int f = 0; f < 42; f++) begin
      for (int i = 0; i < PAYLOAD_BYTES; i++) payload[8*i +: 8] = rand_payload();
      send_frame(payload, 8'd40, 1'b0);
    end
    send_byte(8'h00, 1'b1, 8'd40);
  endtask

  initial begin
    logic [15:0] ox, oy, oz;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed();
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          tx_idle = 22;
          rx_idle = 69;
        end
        1: begin
          tx_idle = 69;
          rx_idle = 22;
        end
        default: begin
          tx_idle = 0;
          rx_idle = 0;
        end
      endcase
      for (int s = 0; s < 2; s++) begin
        case (p * 2 + s)
          0: begin
            ox = 16'h8000; oy = 16'h8000; oz = 16'h8000;
          end
          1: begin
            ox = 16'h7FFF; oy = 16'h7FFF; oz = 16'h7FFF;
          end
          2: begin
            ox = 16'h8000; oy = 16'h7FFF; oz = 16'h0000;
          end
          5: begin
            ox = 16'h0000; oy = 16'hFFFF; oz = 16'h0001;
          end
          default: begin
            ox = 16'($urandom_range(0, 65535));
            oy = 16'($urandom_range(0, 65535));
            oz = 16'($urandom_range(0, 65535));
          end
        endcase
        program_offsets(ox, oy, oz);
        run_traffic(70);
        wait_drained();
        run_traffic(70);
      end
    end
    long_batch();
    wait_drained();
    repeat (10) @(posedge clk);
    if (frames.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
